@@ hdl/jss_pkg.sv @@
package jss_pkg;

   localparam int unsigned TOTAL_W = 9;
   localparam int unsigned LANES = 8;
   localparam int unsigned CLOCKS_W = 4;

   localparam logic [1:0] FUNC_SHIFT = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_READ = 2'd2;
   localparam logic [1:0] FUNC_TMS = 2'd3;

   typedef struct packed {
      logic [1:0]         func;
      logic               start_req;
      logic [TOTAL_W-1:0] total_bits;
      logic [LANES-1:0]   tdi_byte;
      logic [LANES-1:0]   tdo_pins;
   } req_type;

   typedef struct packed {
      logic [LANES-1:0]    tdi_wave;
      logic [LANES-1:0]    tms_wave;
      logic [CLOCKS_W-1:0] clock_count;
      logic [LANES-1:0]    tdo_captured;
      logic                tck_final;
      logic                tms_final;
      logic                done_res;
   } rsp_type;

   // classified command as handed from front to back
   typedef struct packed {
      logic               is_tms;
      logic               drive_tdi;
      logic               capture;
      logic               hold;
      logic               start_req;
      logic [TOTAL_W-1:0] total_bits;
      logic [LANES-1:0]   tdi_byte;
      logic [LANES-1:0]   tdo_pins;
      logic [LANES-1:0]   tms_pattern;
      logic               tms_last;
   } cmd_type;

endpackage

@@ hdl/jss_fifo.sv @@
module jss_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] data_in,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] data_out,
   output logic             empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign data_out = slot_ff[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] res;
      if (ptr == PTR_W'(DEPTH - 1)) begin
         res = '0;
      end else begin
         res = ptr + PTR_W'(1);
      end
      return res;
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= data_in;
      end
   end

endmodule

@@ hdl/jss_front.sv @@
module jss_front #(
   parameter int unsigned MAX_CHUNK_BITS = 488,
   parameter int unsigned TMS_SEQ_BITS = 7,
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  jss_pkg::req_type req_data,
   output logic             req_full,
   input  logic             cmd_pop,
   output jss_pkg::cmd_type cmd_data,
   output logic             cmd_empty
);

   import jss_pkg::*;

   localparam logic [LANES-1:0] SEQ_MASK = LANES'((9'd1 << TMS_SEQ_BITS) - 9'd1);

   cmd_type          cmd_in;
   logic [$bits(cmd_type)-1:0] cmd_bits;

   always_comb begin
      cmd_in.is_tms = (req_data.func == FUNC_TMS);
      cmd_in.drive_tdi = (req_data.func != FUNC_READ);
      cmd_in.capture = (req_data.func == FUNC_SHIFT) || (req_data.func == FUNC_READ);
      cmd_in.hold = ({23'd0, req_data.total_bits} == 32'(MAX_CHUNK_BITS));
      cmd_in.start_req = req_data.start_req;
      cmd_in.total_bits = req_data.total_bits;
      cmd_in.tdi_byte = req_data.tdi_byte;
      cmd_in.tdo_pins = req_data.tdo_pins;
      cmd_in.tms_pattern = req_data.tdi_byte & SEQ_MASK;
      cmd_in.tms_last = req_data.tdi_byte[TMS_SEQ_BITS-1];
   end

   jss_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .data_in  (cmd_in),
      .full     (req_full),
      .pop      (cmd_pop),
      .data_out (cmd_bits),
      .empty    (cmd_empty)
   );

   assign cmd_data = cmd_type'(cmd_bits);

endmodule

@@ hdl/jss_back.sv @@
module jss_back #(
   parameter int unsigned TMS_SEQ_BITS = 7,
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  jss_pkg::cmd_type cmd_data,
   input  logic             cmd_empty,
   output logic             cmd_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output jss_pkg::rsp_type rsp_data
);

   import jss_pkg::*;

   logic [TOTAL_W-1:0]  bits_done_ff, bits_done_in;
   logic                tms_level_ff, tms_level_in;
   logic                tdi_level_ff, tdi_level_in;
   logic                res_full;
   logic                step;
   logic [TOTAL_W-1:0]  base;
   logic [TOTAL_W-1:0]  remaining;
   logic [CLOCKS_W-1:0] clocks;
   logic [LANES-1:0]    mask;
   logic [2:0]          last_idx;
   logic [LANES-1:0]    tms_pos;
   logic [LANES-1:0]    tdi_w;
   logic [LANES-1:0]    tms_w;
   rsp_type             res_in;
   logic [$bits(rsp_type)-1:0] res_bits;

   assign step = !cmd_empty && !res_full;
   assign cmd_pop = step;

   always_comb begin
      base = cmd_data.start_req ? '0 : bits_done_ff;
      remaining = (cmd_data.total_bits > base) ? cmd_data.total_bits - base : '0;
      clocks = (remaining >= TOTAL_W'(LANES)) ? CLOCKS_W'(LANES) : {1'b0, remaining[2:0]};
      mask = LANES'((9'd1 << clocks) - 9'd1);
      last_idx = 3'(clocks - CLOCKS_W'(1));
      // TMS marks the bit whose position is the command's last
      for (int i = 0; i < LANES; i++) begin
         tms_pos[i] = (({1'b0, base} + 10'(i) + 10'd1) == {1'b0, cmd_data.total_bits});
      end
      tdi_w = cmd_data.drive_tdi ? cmd_data.tdi_byte & mask : {LANES{tdi_level_ff}} & mask;
      tms_w = cmd_data.hold ? {LANES{tms_level_ff}} & mask : tms_pos & mask;

      bits_done_in = base + TOTAL_W'(clocks);
      tdi_level_in = tdi_level_ff;
      tms_level_in = tms_level_ff;
      if (clocks != '0) begin
         tdi_level_in = tdi_w[last_idx];
         tms_level_in = tms_w[last_idx];
      end

      res_in.tdi_wave = tdi_w;
      res_in.tms_wave = tms_w;
      res_in.clock_count = clocks;
      res_in.tdo_captured = cmd_data.capture ? cmd_data.tdo_pins & mask : '0;
      res_in.tck_final = 1'b1;
      res_in.tms_final = tms_level_in;
      res_in.done_res = (bits_done_in >= cmd_data.total_bits);

      if (cmd_data.is_tms) begin
         bits_done_in = '0;
         tdi_level_in = 1'b0;
         tms_level_in = cmd_data.tms_last;
         res_in.tdi_wave = '0;
         res_in.tms_wave = cmd_data.tms_pattern;
         res_in.clock_count = CLOCKS_W'(TMS_SEQ_BITS);
         res_in.tdo_captured = '0;
         res_in.tck_final = 1'b0;
         res_in.tms_final = cmd_data.tms_last;
         res_in.done_res = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_done_ff <= '0;
         tms_level_ff <= 1'b0;
         tdi_level_ff <= 1'b0;
      end else if (step) begin
         bits_done_ff <= bits_done_in;
         tms_level_ff <= tms_level_in;
         tdi_level_ff <= tdi_level_in;
      end
   end

   jss_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (step),
      .data_in  (res_in),
      .full     (res_full),
      .pop      (rsp_pop),
      .data_out (res_bits),
      .empty    (rsp_empty)
   );

   assign rsp_data = rsp_type'(res_bits);

endmodule

@@ hdl/jtag_shift_sequencer.sv @@
// Flow: a transferred chunk is classified into the command queue, then executed by the back
// end into the result queue, from whose head rsp_data is read.
// Throughput: one chunk per cycle while the result queue is not full and a command waits.
// Reset (synchronous, active high) empties both queues and clears the bit count and the
// TMS and TDI levels.
module jtag_shift_sequencer #(
   parameter int unsigned MAX_CHUNK_BITS = 488,
   parameter int unsigned TMS_SEQ_BITS = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  jss_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output jss_pkg::rsp_type rsp_data
);

   import jss_pkg::*;

   cmd_type cmd_data;
   logic    cmd_empty;
   logic    cmd_pop;

   jss_front #(
      .MAX_CHUNK_BITS (MAX_CHUNK_BITS),
      .TMS_SEQ_BITS   (TMS_SEQ_BITS),
      .QUEUE_DEPTH    (2)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data),
      .cmd_empty (cmd_empty)
   );

   jss_back #(
      .TMS_SEQ_BITS (TMS_SEQ_BITS),
      .QUEUE_DEPTH  (2)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_data  (cmd_data),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
